>>> src/mpid_pkg.sv
// Shared types, constants and codes for the DC motor PI/PID controller.
package mpid_pkg;

  // Encoder count that maps to position zero, and current sensor midpoint.
  localparam int COUNT_ZERO     = 32000;
  localparam int CURRENT_OFFSET = 512;

  // Reciprocal of 5 scaled by 2^25 and rounded up, used by the current filter.
  localparam int RECIP5_SHIFT = 25;
  localparam int RECIP5       = 6710887;

  // Drive limits and deadband in whole drive units.
  localparam int DRIVE_MAX = 127;
  localparam int DEADBAND  = 20;
  localparam int SPD_ILIM  = 255;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 23;

  // Commands carried in the input beat.
  typedef enum logic [2:0] {
    CMD_TICK    = 3'd0,
    CMD_CURRENT = 3'd1,
    CMD_GOAL    = 3'd2,
    CMD_SPEED   = 3'd3,
    CMD_STOP    = 3'd4,
    CMD_MODE    = 3'd5
  } cmd_e;

  // Configuration register indexes.
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_POS_KP   = 3'd0,
    REG_POS_KI   = 3'd1,
    REG_POS_KD   = 3'd2,
    REG_SPD_KP   = 3'd3,
    REG_SPD_KI   = 3'd4,
    REG_POS_ILIM = 3'd5,
    REG_TRAVEL   = 3'd6,
    REG_CUR_LIM  = 3'd7
  } cfg_reg_e;

  // What a beat does to the held drive outputs once it reaches the last stage.
  typedef enum logic [1:0] {
    DRV_HOLD,
    DRV_LOOP,
    DRV_STOP
  } drv_kind_e;

  typedef struct packed {
    logic signed [15:0] pos_kp;
    logic signed [15:0] pos_ki;
    logic signed [15:0] pos_kd;
    logic signed [15:0] spd_kp;
    logic signed [15:0] spd_ki;
    logic [22:0]        pos_ilim;
    logic [15:0]        travel_max;
    logic [9:0]         cur_lim;
  } cfg_t;

  typedef struct packed {
    logic [2:0]         cmd;
    logic [15:0]        encoder_count;
    logic [9:0]         current_sample;
    logic [15:0]        goal_counts;
    logic signed [15:0] speed_target;
    logic               speed_mode;
  } in_item_t;

  // Loop operands and status after the state update stage.
  typedef struct packed {
    drv_kind_e          kind;
    logic signed [17:0] a1;
    logic signed [23:0] a2;
    logic signed [18:0] a3;
    logic signed [15:0] k1;
    logic signed [15:0] k2;
    logic signed [15:0] k3;
    logic               oc;
    logic               moving;
    logic signed [15:0] position;
  } ops_t;

  // Gain products after the multiply stage.
  typedef struct packed {
    drv_kind_e          kind;
    logic signed [33:0] p1;
    logic signed [39:0] p2;
    logic signed [34:0] p3;
    logic               oc;
    logic               moving;
    logic signed [15:0] position;
  } prod_t;

  typedef struct packed {
    logic               drive_a;
    logic               drive_b_is_pwm;
    logic [7:0]         drive_b_duty;
    logic               over_current;
    logic               moving;
    logic signed [15:0] position_counts;
  } result_t;

endpackage

>>> src/mpid_cfg.sv
// Configuration register file of the motor controller.
module mpid_cfg (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [mpid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mpid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output mpid_pkg::cfg_t                 cfg_o
);
  import mpid_pkg::*;

  cfg_t cfg_q;

  // Writes are always taken.
  assign cfg_ready_o = 1'b1;
  assign cfg_o       = cfg_q;

  // One register per index, reset to its documented value.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.pos_kp     <= 16'sd256;
      cfg_q.pos_ki     <= 16'sd0;
      cfg_q.pos_kd     <= 16'sd0;
      cfg_q.spd_kp     <= 16'sd256;
      cfg_q.spd_ki     <= 16'sd0;
      cfg_q.pos_ilim   <= 23'd65535;
      cfg_q.travel_max <= 16'hFFFF;
      cfg_q.cur_lim    <= 10'd1023;
    end else if (cfg_valid_i) begin
      case (cfg_reg_e'(cfg_index_i))
        REG_POS_KP:   cfg_q.pos_kp     <= cfg_data_i[15:0];
        REG_POS_KI:   cfg_q.pos_ki     <= cfg_data_i[15:0];
        REG_POS_KD:   cfg_q.pos_kd     <= cfg_data_i[15:0];
        REG_SPD_KP:   cfg_q.spd_kp     <= cfg_data_i[15:0];
        REG_SPD_KI:   cfg_q.spd_ki     <= cfg_data_i[15:0];
        REG_POS_ILIM: cfg_q.pos_ilim   <= cfg_data_i;
        REG_TRAVEL:   cfg_q.travel_max <= cfg_data_i[15:0];
        REG_CUR_LIM:  cfg_q.cur_lim    <= cfg_data_i[9:0];
        default: ;
      endcase
    end
  end

endmodule

>>> src/mpid_state.sv
// Input register and controller state update; emits loop operands per beat.
module mpid_state (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  mpid_pkg::cfg_t     cfg_i,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  mpid_pkg::in_item_t in_item_i,
  output logic               ops_valid_o,
  input  logic               ops_ready_i,
  output mpid_pkg::ops_t     ops_o
);
  import mpid_pkg::*;

  // Input register
  in_item_t in_q;
  logic     in_valid_q;
  logic     adv;
  logic     ops_free;

  // Controller state
  logic [15:0]        last_count_q, last_count_d;
  logic [15:0]        goal_q, goal_d;
  logic signed [17:0] last_err_q, last_err_d;
  logic signed [23:0] pos_sum_q, pos_sum_d;
  logic signed [9:0]  spd_sum_q, spd_sum_d;
  logic signed [15:0] setpoint_q, setpoint_d;
  logic               speed_on_q, speed_on_d;
  logic signed [19:0] cf_q, cf_d;
  logic [15:0]        seen_q, seen_d;

  // Stage register
  ops_t ops_q, ops_d;
  logic ops_valid_q;

  // Datapath signals
  logic signed [16:0] pos_full;
  logic [15:0]        pos16;
  logic signed [15:0] speed;
  logic signed [16:0] spd_e;
  logic signed [17:0] spd_acc;
  logic signed [9:0]  spd_sum_c;
  logic signed [17:0] pos_e;
  logic signed [18:0] pos_d;
  logic signed [24:0] pos_acc;
  logic signed [24:0] pos_lim;
  logic signed [23:0] pos_sum_c;
  logic signed [10:0] cur_v;
  logic signed [22:0] filt_n;
  logic [22:0]        filt_m;
  logic [45:0]        filt_prod;
  logic [19:0]        filt_q;
  logic [19:0]        cf_mag;
  logic               oc_now;
  logic [15:0]        goal_req;
  logic [15:0]        stop_goal;
  logic [15:0]        pos_out;
  logic signed [16:0] pos_seen;
  logic signed [17:0] move_err;

  assign ops_free    = !ops_valid_q || ops_ready_i;
  assign adv         = in_valid_q && ops_free;
  assign in_ready_o  = !in_valid_q || ops_free;
  assign ops_valid_o = ops_valid_q;
  assign ops_o       = ops_q;

  // Position and speed loop arithmetic.
  always_comb begin
    pos_full = $signed({1'b0, in_q.encoder_count}) - 17'(COUNT_ZERO);
    pos16    = pos_full[15:0];
    speed    = $signed(pos16 - last_count_q);
    spd_e    = 17'(speed) - 17'(setpoint_q);
    spd_acc  = 18'(spd_sum_q) + 18'(spd_e);
    if (spd_acc > 18'(SPD_ILIM)) begin
      spd_sum_c = 10'(SPD_ILIM);
    end else if (spd_acc < -18'(SPD_ILIM)) begin
      spd_sum_c = -10'(SPD_ILIM);
    end else begin
      spd_sum_c = spd_acc[9:0];
    end

    pos_e   = $signed({2'b00, goal_q}) - 18'(pos_full);
    pos_d   = 19'(pos_e) - 19'(last_err_q);
    pos_acc = 25'(pos_sum_q) + 25'(pos_e);
    pos_lim = $signed({2'b00, cfg_i.pos_ilim});
    if (pos_acc > pos_lim) begin
      pos_sum_c = pos_lim[23:0];
    end else if (pos_acc < -pos_lim) begin
      pos_sum_c = 24'(-pos_lim);
    end else begin
      pos_sum_c = pos_acc[23:0];
    end
  end

  // Current low-pass: (4*old + 256*v) / 5, rounded half away from zero.
  always_comb begin
    cur_v     = $signed({1'b0, in_q.current_sample}) - 11'(CURRENT_OFFSET);
    filt_n    = (23'(cf_q) <<< 2) + (23'(cur_v) <<< 8);
    filt_m    = (filt_n[22] ? 23'(-filt_n) : filt_n) + 23'd2;
    filt_prod = 46'(filt_m) * 46'(RECIP5);
    filt_q    = filt_prod[RECIP5_SHIFT+19:RECIP5_SHIFT];
    cf_mag    = cf_q[19] ? 20'(-cf_q) : cf_q;
    oc_now    = cf_mag > {2'b00, cfg_i.cur_lim, 8'h00};
  end

  // Goal clamps for set goal and stop.
  always_comb begin
    goal_req = (in_q.goal_counts > cfg_i.travel_max) ? cfg_i.travel_max : in_q.goal_counts;
    if (pos_full < 17'sd0) begin
      stop_goal = 16'd0;
    end else if (pos_full[15:0] > cfg_i.travel_max) begin
      stop_goal = cfg_i.travel_max;
    end else begin
      stop_goal = pos_full[15:0];
    end
  end

  // Next state and loop operands per command.
  always_comb begin
    last_count_d = last_count_q;
    goal_d       = goal_q;
    last_err_d   = last_err_q;
    pos_sum_d    = pos_sum_q;
    spd_sum_d    = spd_sum_q;
    setpoint_d   = setpoint_q;
    speed_on_d   = speed_on_q;
    cf_d         = cf_q;
    seen_d       = seen_q;
    ops_d        = '0;
    ops_d.kind   = DRV_HOLD;
    ops_d.oc     = oc_now;
    case (in_q.cmd)
      CMD_TICK: begin
        seen_d     = in_q.encoder_count;
        ops_d.kind = DRV_LOOP;
        if (speed_on_q) begin
          // Speed loop drives the negated PI output; zero setpoint means no drive.
          last_count_d = pos16;
          ops_d.k1     = cfg_i.spd_kp;
          ops_d.k2     = cfg_i.spd_ki;
          if (setpoint_q == 16'sd0) begin
            spd_sum_d = '0;
          end else begin
            spd_sum_d = spd_sum_c;
            ops_d.a1  = -18'(spd_e);
            ops_d.a2  = -24'(spd_sum_c);
          end
        end else begin
          pos_sum_d  = pos_sum_c;
          last_err_d = pos_e;
          ops_d.a1   = pos_e;
          ops_d.a2   = pos_sum_c;
          ops_d.a3   = pos_d;
          ops_d.k1   = cfg_i.pos_kp;
          ops_d.k2   = cfg_i.pos_ki;
          ops_d.k3   = cfg_i.pos_kd;
        end
      end
      CMD_CURRENT: begin
        cf_d = filt_n[22] ? -$signed(filt_q) : $signed(filt_q);
      end
      CMD_GOAL: begin
        goal_d = goal_req;
      end
      CMD_SPEED: begin
        setpoint_d = in_q.speed_target;
      end
      CMD_STOP: begin
        seen_d     = in_q.encoder_count;
        ops_d.kind = DRV_STOP;
        setpoint_d = '0;
        goal_d     = stop_goal;
        last_err_d = '0;
        pos_sum_d  = '0;
        spd_sum_d  = '0;
      end
      CMD_MODE: begin
        seen_d = in_q.encoder_count;
        if (in_q.speed_mode) begin
          spd_sum_d    = '0;
          setpoint_d   = '0;
          last_count_d = pos16;
          speed_on_d   = 1'b1;
        end else begin
          speed_on_d = 1'b0;
        end
      end
      default: ;
    endcase

    // Reported position and motion from the updated state; the error uses the
    // full-width position so that counts above the signed range compare right.
    pos_out        = seen_d - 16'(COUNT_ZERO);
    pos_seen       = $signed({1'b0, seen_d}) - 17'(COUNT_ZERO);
    move_err       = $signed({2'b00, goal_d}) - 18'(pos_seen);
    ops_d.position = $signed(pos_out);
    if (speed_on_d) begin
      ops_d.moving = setpoint_d != 16'sd0;
    end else begin
      ops_d.moving = (move_err > 18'sd1) || (move_err < -18'sd1);
    end
  end

  // Input register handshake.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (in_ready_o) begin
      in_valid_q <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_item_i;
    end
  end

  // State registers advance as a beat leaves the input register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      last_count_q <= '0;
      goal_q       <= '0;
      last_err_q   <= '0;
      pos_sum_q    <= '0;
      spd_sum_q    <= '0;
      setpoint_q   <= '0;
      speed_on_q   <= 1'b1;
      cf_q         <= '0;
      seen_q       <= 16'(COUNT_ZERO);
    end else if (adv) begin
      last_count_q <= last_count_d;
      goal_q       <= goal_d;
      last_err_q   <= last_err_d;
      pos_sum_q    <= pos_sum_d;
      spd_sum_q    <= spd_sum_d;
      setpoint_q   <= setpoint_d;
      speed_on_q   <= speed_on_d;
      cf_q         <= cf_d;
      seen_q       <= seen_d;
    end
  end

  // Operand stage register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ops_valid_q <= 1'b0;
    end else if (ops_free) begin
      ops_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ops_q <= ops_d;
    end
  end

endmodule

>>> src/mpid_mult.sv
// Gain multiply stage: three signed products, registered.
module mpid_mult (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            ops_valid_i,
  output logic            ops_ready_o,
  input  mpid_pkg::ops_t  ops_i,
  output logic            prod_valid_o,
  input  logic            prod_ready_i,
  output mpid_pkg::prod_t prod_o
);
  import mpid_pkg::*;

  prod_t prod_q, prod_d;
  logic  prod_valid_q;

  assign ops_ready_o  = !prod_valid_q || prod_ready_i;
  assign prod_valid_o = prod_valid_q;
  assign prod_o       = prod_q;

  // Exact products of operands and Q8.8 gains.
  always_comb begin
    prod_d.kind     = ops_i.kind;
    prod_d.p1       = 34'(ops_i.a1) * 34'(ops_i.k1);
    prod_d.p2       = 40'(ops_i.a2) * 40'(ops_i.k2);
    prod_d.p3       = 35'(ops_i.a3) * 35'(ops_i.k3);
    prod_d.oc       = ops_i.oc;
    prod_d.moving   = ops_i.moving;
    prod_d.position = ops_i.position;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else if (ops_ready_o) begin
      prod_valid_q <= ops_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ops_valid_i && ops_ready_o) begin
      prod_q <= prod_d;
    end
  end

endmodule

>>> src/mpid_drive.sv
// Loop sum, overcurrent cut, saturation, deadband and the result register.
module mpid_drive (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              prod_valid_i,
  output logic              prod_ready_o,
  input  mpid_pkg::prod_t   prod_i,
  output logic              res_valid_o,
  input  logic              res_ready_i,
  output mpid_pkg::result_t res_o
);
  import mpid_pkg::*;

  result_t res_q;
  logic    res_valid_q;
  logic    load;

  logic signed [41:0] loop_sum;
  logic signed [41:0] loop_adj;
  logic signed [41:0] loop_div;
  logic signed [7:0]  cmd_sat;
  logic signed [8:0]  duty_w;
  logic               dead;

  assign prod_ready_o = !res_valid_q || res_ready_i;
  assign load         = prod_valid_i && prod_ready_o;
  assign res_valid_o  = res_valid_q;
  assign res_o        = res_q;

  // Sum the terms, divide by 256 toward zero, then cut and saturate.
  always_comb begin
    loop_sum = 42'(prod_i.p1) + 42'(prod_i.p2) + 42'(prod_i.p3);
    loop_adj = loop_sum + (loop_sum[41] ? 42'sd255 : 42'sd0);
    loop_div = loop_adj >>> 8;
    if (prod_i.oc) begin
      cmd_sat = '0;
    end else if (loop_div > 42'(DRIVE_MAX)) begin
      cmd_sat = 8'(DRIVE_MAX);
    end else if (loop_div < -42'(DRIVE_MAX)) begin
      cmd_sat = -8'(DRIVE_MAX);
    end else begin
      cmd_sat = loop_div[7:0];
    end
    dead   = (cmd_sat > -8'(DEADBAND)) && (cmd_sat < 8'(DEADBAND));
    duty_w = 9'(cmd_sat) + 9'(DRIVE_MAX);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else if (prod_ready_o) begin
      res_valid_q <= prod_valid_i;
    end
  end

  // Drive fields hold between tick and stop beats; they reset to A high, B low.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_q.drive_a         <= 1'b1;
      res_q.drive_b_is_pwm  <= 1'b0;
      res_q.drive_b_duty    <= '0;
      res_q.over_current    <= 1'b0;
      res_q.moving          <= 1'b0;
      res_q.position_counts <= '0;
    end else if (load) begin
      res_q.moving          <= prod_i.moving;
      res_q.position_counts <= prod_i.position;
      case (prod_i.kind)
        DRV_LOOP: begin
          res_q.drive_a        <= dead;
          res_q.drive_b_is_pwm <= !dead;
          res_q.drive_b_duty   <= dead ? 8'd0 : duty_w[7:0];
          res_q.over_current   <= prod_i.oc;
        end
        DRV_STOP: begin
          res_q.drive_a        <= 1'b0;
          res_q.drive_b_is_pwm <= 1'b0;
          res_q.drive_b_duty   <= '0;
          res_q.over_current   <= 1'b0;
        end
        default: ;
      endcase
    end
  end

endmodule

>>> src/dc_motor_pi_pid_controller.sv
// Top level of the DC motor controller with PI speed and PID position loops.
//
//  Channel   Direction  Beat contents (low bits first)
//  s_axis    in         tuser: cmd; tdata: encoder, current, goal, speed, mode
//  m_axis    out        tdata: drive_a, b_is_pwm, b_duty, over_current, moving, pos
//  cfg       in         cfg_index_i selects register, cfg_data_i is the value
//
// One beat is accepted per cycle unless a stalled result stream has filled the stages;
// a result passes the operand, product and result registers behind the input register.
// The state update between the input and operand registers sets that rate.
// Reset is asynchronous and active low; no clearing pass is needed.
// A stalled result holds each stage that is full; empty stages still fill.
module dc_motor_pi_pid_controller (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  output logic                            s_axis_tready,
  // [15:0] encoder_count, [25:16] current_sample, [41:26] goal_counts,
  // [57:42] speed_target, [58] speed_mode, rest zero
  input  logic [63:0]                     s_axis_tdata,
  // [2:0] cmd
  input  logic [2:0]                      s_axis_tuser,
  output logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  // [0] drive_a, [1] drive_b_is_pwm, [9:2] drive_b_duty, [10] over_current,
  // [11] moving, [27:12] position_counts, rest zero
  output logic [31:0]                     m_axis_tdata,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [mpid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mpid_pkg::CFG_DATA_W-1:0] cfg_data_i
);
  import mpid_pkg::*;

  cfg_t     cfg;
  in_item_t in_item;
  ops_t     ops;
  prod_t    prod;
  result_t  res;
  logic     ops_valid, ops_ready;
  logic     prod_valid, prod_ready;

  // Unpack the input beat.
  always_comb begin
    in_item.cmd            = s_axis_tuser;
    in_item.encoder_count  = s_axis_tdata[15:0];
    in_item.current_sample = s_axis_tdata[25:16];
    in_item.goal_counts    = s_axis_tdata[41:26];
    in_item.speed_target   = s_axis_tdata[57:42];
    in_item.speed_mode     = s_axis_tdata[58];
  end

  mpid_cfg u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .cfg_o       (cfg)
  );

  mpid_state u_state (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_i       (cfg),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .in_item_i   (in_item),
    .ops_valid_o (ops_valid),
    .ops_ready_i (ops_ready),
    .ops_o       (ops)
  );

  mpid_mult u_mult (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ops_valid_i  (ops_valid),
    .ops_ready_o  (ops_ready),
    .ops_i        (ops),
    .prod_valid_o (prod_valid),
    .prod_ready_i (prod_ready),
    .prod_o       (prod)
  );

  mpid_drive u_drive (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .prod_valid_i (prod_valid),
    .prod_ready_o (prod_ready),
    .prod_i       (prod),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_o        (res)
  );

  // Pack the result beat.
  assign m_axis_tdata = {4'h0, res.position_counts, res.moving, res.over_current,
                         res.drive_b_duty, res.drive_b_is_pwm, res.drive_a};

endmodule

>>> src/mpid_checker.sv
// Port-level checks on the motor controller's result stream, bound to the top level.
module mpid_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        m_axis_tvalid,
  input logic        m_axis_tready,
  input logic [31:0] m_axis_tdata
);

  // A stalled result beat keeps its contents.
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result beat changed while stalled");

  // Bridge input A and PWM on B are never on together.
  a_bridge: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> !(m_axis_tdata[0] && m_axis_tdata[1]))
    else $error("drive A high while B is PWM");

  // Without PWM the duty reads zero.
  a_duty_off: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tdata[1] |-> m_axis_tdata[9:2] == 8'd0)
    else $error("nonzero duty with B held low");

  // A PWM duty lies outside the deadband and within the saturation range.
  a_duty_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[1] |->
      (m_axis_tdata[9:2] <= 8'd107 || m_axis_tdata[9:2] >= 8'd147) &&
      m_axis_tdata[9:2] != 8'd255)
    else $error("PWM duty inside deadband or out of range");

  // An overcurrent cut leaves the bridge in the deadband state.
  a_oc_cut: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && m_axis_tdata[10] |-> m_axis_tdata[0] && !m_axis_tdata[1])
    else $error("drive not cut on overcurrent");

endmodule

bind dc_motor_pi_pid_controller mpid_checker u_mpid_checker (.*);

>>> verif/dc_motor_drive_check.sv
// Watches the motor controller channels, predicts every result beat and compares it.
module dc_motor_drive_check (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            s_axis_tvalid,
  input  logic                            s_axis_tready,
  input  logic [63:0]                     s_axis_tdata,
  input  logic [2:0]                      s_axis_tuser,
  input  logic                            m_axis_tvalid,
  input  logic                            m_axis_tready,
  input  logic [31:0]                     m_axis_tdata,
  input  logic                            cfg_valid_i,
  input  logic                            cfg_ready_o,
  input  logic [mpid_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [mpid_pkg::CFG_DATA_W-1:0] cfg_data_i,
  output int                              mismatch_count,
  output int                              results_due
);
  timeunit 1ns;
  timeprecision 1ps;
  import mpid_pkg::*;

  // Shadow copy of the register file and the controller state.
  cfg_t        ctl_cfg;
  logic [15:0] prev_speed_pos;
  logic [15:0] last_enc;
  longint      goal_pos, prev_pos_err, pos_err_acc, spd_err_acc, spd_target, cur_lpf;
  bit          speed_mode_on;
  logic        out_a, out_pwm, out_oc;
  logic [7:0]  out_duty;

  // Predicted result beats, oldest first.
  result_t     drive_results_due[$];

  function automatic void reset_model();
    ctl_cfg.pos_kp     = 16'sd256;
    ctl_cfg.pos_ki     = '0;
    ctl_cfg.pos_kd     = '0;
    ctl_cfg.spd_kp     = 16'sd256;
    ctl_cfg.spd_ki     = '0;
    ctl_cfg.pos_ilim   = 23'd65535;
    ctl_cfg.travel_max = 16'd65535;
    ctl_cfg.cur_lim    = 10'd1023;
    prev_speed_pos = '0;
    last_enc       = 16'(COUNT_ZERO);
    goal_pos       = 0;
    prev_pos_err   = 0;
    pos_err_acc    = 0;
    spd_err_acc    = 0;
    spd_target     = 0;
    cur_lpf        = 0;
    speed_mode_on  = 1'b1;
    out_a          = 1'b1;
    out_pwm        = 1'b0;
    out_duty       = '0;
    out_oc         = 1'b0;
  endfunction

  function automatic longint clamp_to(longint v, longint lo, longint hi);
    return v < lo ? lo : (v > hi ? hi : v);
  endfunction

  // Overcurrent cut, saturation and deadband applied to a loop demand.
  function automatic void set_drive(longint demand);
    longint lim_q8, mag;
    lim_q8 = longint'(ctl_cfg.cur_lim) * 256;
    mag    = cur_lpf < 0 ? -cur_lpf : cur_lpf;
    out_oc = mag > lim_q8;
    if (out_oc) demand = 0;
    demand = clamp_to(demand, -DRIVE_MAX, DRIVE_MAX);
    if (demand > -DEADBAND && demand < DEADBAND) begin
      out_a    = 1'b1;
      out_pwm  = 1'b0;
      out_duty = '0;
    end else begin
      out_a    = 1'b0;
      out_pwm  = 1'b1;
      out_duty = 8'(demand + DRIVE_MAX);
    end
  endfunction

  // Advances the shadow state by one input beat and returns the result it causes.
  function automatic result_t predict_drive(in_item_t it);
    longint      pos_full, err, delta, demand, acc, pos_now;
    logic [15:0] pos16, spd16;
    result_t     r;
    pos_full = longint'(it.encoder_count) - COUNT_ZERO;
    pos16    = it.encoder_count - 16'(COUNT_ZERO);
    if (it.cmd == CMD_TICK || it.cmd == CMD_STOP || it.cmd == CMD_MODE)
      last_enc = it.encoder_count;
    case (it.cmd)
      CMD_TICK: begin
        if (speed_mode_on) begin
          // PI on the count change since the previous tick.
          spd16       = pos16 - prev_speed_pos;
          err         = longint'($signed(spd16)) - spd_target;
          spd_err_acc = clamp_to(spd_err_acc + err, -SPD_ILIM, SPD_ILIM);
          demand      = (err * longint'(ctl_cfg.spd_kp) +
                         spd_err_acc * longint'(ctl_cfg.spd_ki)) / 256;
          if (spd_target == 0) begin
            demand      = 0;
            spd_err_acc = 0;
          end
          set_drive(-demand);
          prev_speed_pos = pos16;
        end else begin
          // PID on goal minus position.
          err          = goal_pos - pos_full;
          delta        = err - prev_pos_err;
          pos_err_acc  = clamp_to(pos_err_acc + err, -longint'(ctl_cfg.pos_ilim),
                                  longint'(ctl_cfg.pos_ilim));
          prev_pos_err = err;
          demand       = (longint'(ctl_cfg.pos_kp) * err +
                          longint'(ctl_cfg.pos_ki) * pos_err_acc +
                          longint'(ctl_cfg.pos_kd) * delta) / 256;
          set_drive(demand);
        end
      end
      CMD_CURRENT: begin
        // Low-pass 0.8/0.2 in Q8, rounded half away from zero.
        acc     = 4 * cur_lpf + 256 * (longint'(it.current_sample) - CURRENT_OFFSET);
        cur_lpf = acc < 0 ? -((-acc + 2) / 5) : (acc + 2) / 5;
      end
      CMD_GOAL: begin
        acc      = longint'(it.goal_counts);
        goal_pos = acc > longint'(ctl_cfg.travel_max) ? longint'(ctl_cfg.travel_max) : acc;
      end
      CMD_SPEED: spd_target = longint'(it.speed_target);
      CMD_STOP: begin
        spd_target   = 0;
        goal_pos     = clamp_to(pos_full, 0, longint'(ctl_cfg.travel_max));
        prev_pos_err = 0;
        pos_err_acc  = 0;
        spd_err_acc  = 0;
        out_a        = 1'b0;
        out_pwm      = 1'b0;
        out_duty     = '0;
        out_oc       = 1'b0;
      end
      CMD_MODE: begin
        if (it.speed_mode) begin
          spd_err_acc    = 0;
          spd_target     = 0;
          prev_speed_pos = pos16;
          speed_mode_on  = 1'b1;
        end else begin
          speed_mode_on = 1'b0;
        end
      end
      default: ;
    endcase
    pos_now             = longint'(last_enc) - COUNT_ZERO;
    err                 = goal_pos - pos_now;
    r.drive_a           = out_a;
    r.drive_b_is_pwm    = out_pwm;
    r.drive_b_duty      = out_duty;
    r.over_current      = out_oc;
    r.moving            = speed_mode_on ? (spd_target != 0) : (err > 1 || err < -1);
    r.position_counts   = pos_now[15:0];
    return r;
  endfunction

  task automatic compare_field(string name, logic signed [31:0] want,
                               logic signed [31:0] got);
    if (want !== got) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, want, got);
      mismatch_count++;
    end
  endtask

  initial begin
    mismatch_count = 0;
    results_due    = 0;
    reset_model();
  end

  // Result beats are checked before the input beat of the same edge is predicted.
  always @(posedge clk_i or negedge rst_ni) begin
    in_item_t beat;
    result_t  want, got;
    if (!rst_ni) begin
      reset_model();
      drive_results_due.delete();
    end else begin
      if (m_axis_tvalid && m_axis_tready) begin
        got.drive_a         = m_axis_tdata[0];
        got.drive_b_is_pwm  = m_axis_tdata[1];
        got.drive_b_duty    = m_axis_tdata[9:2];
        got.over_current    = m_axis_tdata[10];
        got.moving          = m_axis_tdata[11];
        got.position_counts = m_axis_tdata[27:12];
        if (drive_results_due.size() == 0) begin
          $display("%0t: result beat with nothing expected, got %h", $time, m_axis_tdata);
          mismatch_count++;
        end else begin
          want = drive_results_due.pop_front();
          compare_field("drive_a", want.drive_a, got.drive_a);
          compare_field("drive_b_is_pwm", want.drive_b_is_pwm, got.drive_b_is_pwm);
          compare_field("drive_b_duty", want.drive_b_duty, got.drive_b_duty);
          compare_field("over_current", want.over_current, got.over_current);
          compare_field("moving", want.moving, got.moving);
          compare_field("position_counts", want.position_counts, got.position_counts);
        end
      end
      if (cfg_valid_i && cfg_ready_o) begin
        case (cfg_index_i)
          REG_POS_KP:   ctl_cfg.pos_kp     = cfg_data_i[15:0];
          REG_POS_KI:   ctl_cfg.pos_ki     = cfg_data_i[15:0];
          REG_POS_KD:   ctl_cfg.pos_kd     = cfg_data_i[15:0];
          REG_SPD_KP:   ctl_cfg.spd_kp     = cfg_data_i[15:0];
          REG_SPD_KI:   ctl_cfg.spd_ki     = cfg_data_i[15:0];
          REG_POS_ILIM: ctl_cfg.pos_ilim   = cfg_data_i;
          REG_TRAVEL:   ctl_cfg.travel_max = cfg_data_i[15:0];
          REG_CUR_LIM:  ctl_cfg.cur_lim    = cfg_data_i[9:0];
          default: ;
        endcase
      end
      if (s_axis_tvalid && s_axis_tready) begin
        beat.cmd            = s_axis_tuser;
        beat.encoder_count  = s_axis_tdata[15:0];
        beat.current_sample = s_axis_tdata[25:16];
        beat.goal_counts    = s_axis_tdata[41:26];
        beat.speed_target   = s_axis_tdata[57:42];
        beat.speed_mode     = s_axis_tdata[58];
        drive_results_due.push_back(predict_drive(beat));
      end
    end
    results_due = drive_results_due.size();
  end

endmodule

>>> verif/dc_motor_pi_pid_controller_tb.sv
// Stimulus and verdict for the DC motor PI/PID controller.
module dc_motor_pi_pid_controller_tb;
  timeunit 1ns;
  timeprecision 1ps;
  import mpid_pkg::*;

  logic                  clk_i         = 1'b0;
  logic                  rst_ni        = 1'b0;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [63:0]           s_axis_tdata  = '0;
  logic [2:0]            s_axis_tuser  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [31:0]           m_axis_tdata;
  logic                  cfg_valid_i   = 1'b0;
  logic                  cfg_ready_o;
  logic [CFG_IDX_W-1:0]  cfg_index_i   = '0;
  logic [CFG_DATA_W-1:0] cfg_data_i    = '0;

  int          mismatch_count;
  int          results_due;
  // When set, neither side inserts idle cycles.
  bit          calm    = 1'b0;
  // Encoder position that the well-formed ticks follow.
  logic [15:0] enc_now = 16'd32000;

  dc_motor_pi_pid_controller DUT (.*);

  dc_motor_drive_check drive_check (.*);

  always begin
    #4 clk_i = 1'b1;
    #4 clk_i = 1'b0;
  end

  // Mostly no gap, sometimes a short one, rarely a long one.
  function automatic int idle_len();
    int r;
    r = $urandom_range(0, 99);
    if (calm) return 0;
    if (r < 6) return $urandom_range(12, 60);
    if (r < 35) return $urandom_range(1, 4);
    return 0;
  endfunction

  function automatic logic [15:0] typical_gain(int lo, int hi);
    int m;
    m = $urandom_range(lo, hi);
    if ($urandom_range(0, 99) < 15) m = -m;
    return 16'(m);
  endfunction

  // Beat with one command and its argument; the unused fields carry random bits.
  function automatic in_item_t make_beat(cmd_e c, logic [15:0] enc, logic [15:0] arg);
    in_item_t it;
    it.cmd            = c;
    it.encoder_count  = enc;
    it.current_sample = 10'($urandom);
    it.goal_counts    = 16'($urandom);
    it.speed_target   = 16'($urandom);
    it.speed_mode     = 1'($urandom);
    case (c)
      CMD_CURRENT: it.current_sample = arg[9:0];
      CMD_GOAL:    it.goal_counts    = arg;
      CMD_SPEED:   it.speed_target   = arg;
      CMD_MODE:    it.speed_mode     = arg[0];
      default: ;
    endcase
    return it;
  endfunction

  // Mostly plausible motion around the current position, with some noise.
  function automatic in_item_t random_beat();
    int r, g;
    r = $urandom_range(0, 99);
    if ($urandom_range(0, 99) < 3) enc_now = 16'(COUNT_ZERO + $urandom_range(0, 3000));
    if (r < 45) begin
      if ($urandom_range(0, 9) < 8) enc_now = enc_now + 16'($urandom_range(0, 80)) - 16'd40;
      else enc_now = 16'($urandom);
      return make_beat(CMD_TICK, enc_now, 16'($urandom));
    end
    if (r < 60) begin
      if ($urandom_range(0, 3) == 0) g = $urandom_range(0, 1023);
      else g = CURRENT_OFFSET + $urandom_range(0, 600) - 300;
      return make_beat(CMD_CURRENT, 16'($urandom), 16'(g));
    end
    if (r < 70) begin
      g = int'(enc_now) - COUNT_ZERO + $urandom_range(0, 400) - 200;
      if (g < 0) g = 0;
      if ($urandom_range(0, 4) == 0) g = $urandom_range(0, 65535);
      return make_beat(CMD_GOAL, 16'($urandom), 16'(g));
    end
    if (r < 80) begin
      case ($urandom_range(0, 5))
        0:       g = 0;
        1:       g = $urandom_range(0, 65535);
        default: g = $urandom_range(0, 120) - 60;
      endcase
      return make_beat(CMD_SPEED, 16'($urandom), 16'(g));
    end
    if (r < 88) return make_beat(CMD_MODE, enc_now, 16'($urandom));
    if (r < 92) return make_beat(CMD_STOP, enc_now, 16'($urandom));
    return make_beat(cmd_e'($urandom_range(0, 5)), 16'($urandom), 16'($urandom));
  endfunction

  task automatic send_beat(input in_item_t it);
    int gap;
    s_axis_tuser  <= it.cmd;
    s_axis_tdata  <= {5'd0, it.speed_mode, it.speed_target, it.goal_counts,
                      it.current_sample, it.encoder_count};
    s_axis_tvalid <= 1'b1;
    do @(posedge clk_i); while (!s_axis_tready);
    gap = idle_len();
    if (gap > 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
  endtask

  // Holds the input side until every predicted result has come out.
  task automatic settle();
    s_axis_tvalid <= 1'b0;
    @(posedge clk_i);
    wait (results_due == 0);
    repeat (8) @(posedge clk_i);
  endtask

  task automatic write_reg(cfg_reg_e idx, logic [CFG_DATA_W-1:0] val);
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    cfg_valid_i <= 1'b1;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  // Register set for one phase; unused high data bits carry random junk.
  task automatic program_phase(int ph);
    logic [15:0] g [5];
    logic [22:0] ilim;
    logic [15:0] travel;
    logic [9:0]  cur;
    case (ph)
      1: begin
        foreach (g[k]) g[k] = 16'h7FFF;
        ilim = 23'h7FFFFF; travel = 16'hFFFF; cur = 10'h3FF;
      end
      2: begin
        foreach (g[k]) g[k] = 16'h8000;
        ilim = '0; travel = '0; cur = '0;
      end
      7: begin
        foreach (g[k]) g[k] = 16'($urandom);
        ilim = 23'($urandom); travel = 16'($urandom); cur = 10'($urandom);
      end
      default: begin
        g[0] = typical_gain(32, 1024);
        g[1] = typical_gain(0, 64);
        g[2] = typical_gain(0, 600);
        g[3] = typical_gain(64, 1024);
        g[4] = typical_gain(0, 128);
        ilim   = 23'($urandom_range(0, 20000));
        travel = 16'($urandom_range(1000, 40000));
        cur    = 10'($urandom_range(80, 400));
      end
    endcase
    write_reg(REG_POS_KP, {7'($urandom), g[0]});
    write_reg(REG_POS_KI, {7'($urandom), g[1]});
    write_reg(REG_POS_KD, {7'($urandom), g[2]});
    write_reg(REG_SPD_KP, {7'($urandom), g[3]});
    write_reg(REG_SPD_KI, {7'($urandom), g[4]});
    write_reg(REG_POS_ILIM, ilim);
    write_reg(REG_TRAVEL, {7'($urandom), travel});
    write_reg(REG_CUR_LIM, {13'($urandom), cur});
  endtask

  // Result side: bursts of ready broken by random stalls.
  initial begin
    int stall;
    wait (rst_ni);
    @(posedge clk_i);
    forever begin
      m_axis_tready <= 1'b1;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
      stall = idle_len();
      if (stall > 0) begin
        m_axis_tready <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
    end
  end

  initial begin
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed part at the reset register values: speed loop first.
    send_beat(make_beat(CMD_TICK, 16'd32000, 16'd0));
    send_beat(make_beat(CMD_SPEED, 16'($urandom), 16'h7FFF));
    send_beat(make_beat(CMD_TICK, 16'hFFFF, 16'd0));
    send_beat(make_beat(CMD_SPEED, 16'($urandom), 16'h8000));
    send_beat(make_beat(CMD_TICK, 16'h0000, 16'd0));
    send_beat(make_beat(CMD_SPEED, 16'($urandom), 16'd30));
    send_beat(make_beat(CMD_TICK, 16'd32050, 16'd0));
    // Current filter at both rail readings and the midpoint.
    send_beat(make_beat(CMD_CURRENT, 16'($urandom), 16'd0));
    send_beat(make_beat(CMD_CURRENT, 16'($urandom), 16'd1023));
    send_beat(make_beat(CMD_CURRENT, 16'($urandom), 16'd512));
    // Position loop with goals at the ends of travel and a one-count error.
    send_beat(make_beat(CMD_MODE, 16'd32000, 16'd0));
    send_beat(make_beat(CMD_GOAL, 16'($urandom), 16'hFFFF));
    send_beat(make_beat(CMD_TICK, 16'h0000, 16'd0));
    send_beat(make_beat(CMD_TICK, 16'hFFFF, 16'd0));
    send_beat(make_beat(CMD_GOAL, 16'($urandom), 16'd1));
    send_beat(make_beat(CMD_TICK, 16'd32000, 16'd0));
    send_beat(make_beat(CMD_GOAL, 16'($urandom), 16'd2));
    // Stop at the top encoder count and below the travel range, then back to speed mode.
    send_beat(make_beat(CMD_STOP, 16'hFFFF, 16'd0));
    send_beat(make_beat(CMD_STOP, 16'h0000, 16'd0));
    send_beat(make_beat(CMD_MODE, 16'd123, 16'd1));
    send_beat(make_beat(CMD_TICK, 16'd123, 16'd0));

    // Random phases, each under its own register set.
    for (int ph = 0; ph < 8; ph++) begin
      settle();
      calm = (ph == 4);
      program_phase(ph);
      enc_now = 16'(COUNT_ZERO + $urandom_range(0, 2000));
      repeat (235) send_beat(random_beat());
    end
    calm = 1'b0;
    settle();

    if (mismatch_count == 0 && results_due == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> dc_motor_pi_pid_controller.f
src/mpid_pkg.sv
src/mpid_cfg.sv
src/mpid_state.sv
src/mpid_mult.sv
src/mpid_drive.sv
src/dc_motor_pi_pid_controller.sv
src/mpid_checker.sv
verif/dc_motor_drive_check.sv
verif/dc_motor_pi_pid_controller_tb.sv
